// File: design/psr_pkg.sv
// Shared types and constants of the packet sequence reassembler.
`timescale 1ns / 1ps
`default_nettype none
package psr_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RELIABLE_MODE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_CAPACITY = 8'd1;

    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    typedef enum logic [2:0] {
        ST_ACCEPT  = 3'd0,
        ST_FIRST   = 3'd1,
        ST_REPEAT  = 3'd2,
        ST_MISSED  = 3'd3,
        ST_OMIT    = 3'd4,
        ST_SMALL   = 3'd5,
        ST_TIMEOUT = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        DONE_CONTINUE = 2'd0,
        DONE_OK       = 2'd1,
        DONE_ERROR    = 2'd2
    } done_t;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_TIMEOUT = 1'b1
    } kind_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pkt_count;
        logic        first_flag;
        logic        last_flag;
        logic [10:0] byte_len;
    } psr_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        ack_send;
        logic [7:0]  ack_count;
        logic        write_enable;
        logic [15:0] write_offset;
        logic [1:0]  sequence_done;
        logic [15:0] total_bytes;
    } psr_out_t;

    typedef struct packed {
        logic        reliable_mode;
        logic [15:0] buffer_capacity;
        logic        cap_load;
        logic [15:0] cap_value;
    } psr_cfg_t;

endpackage
`default_nettype wire

// File: design/psr_cfg_regs.sv
// Configuration registers of the packet sequence reassembler.
`timescale 1ns / 1ps
`default_nettype none
module psr_cfg_regs
    import psr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output psr_cfg_t                    cfg
);

    logic        reliable_reg;
    logic [15:0] capacity_reg;
    logic        wr_mode;
    logic        wr_cap;

    assign cfg_ready = 1'b1;
    assign wr_mode   = cfg_valid && (cfg_index == REG_RELIABLE_MODE);
    assign wr_cap    = cfg_valid && (cfg_index == REG_BUFFER_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reliable_reg <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
        end else begin
            if (wr_mode) begin
                reliable_reg <= cfg_data[0];
            end
            if (wr_cap) begin
                capacity_reg <= cfg_data[15:0];
            end
        end
    end

    always_comb begin
        cfg.reliable_mode   = reliable_reg;
        cfg.buffer_capacity = capacity_reg;
        cfg.cap_load        = wr_cap;
        cfg.cap_value       = cfg_data[15:0];
    end

endmodule
`default_nettype wire

// File: design/psr_core.sv
// Sequence state and per-word classification of the packet sequence reassembler.
`timescale 1ns / 1ps
`default_nettype none
module psr_core
    import psr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  psr_in_t       in_word,
    input  psr_cfg_t      cfg,
    output psr_out_t      result
);

    localparam logic [15:0] MaxPayload = 16'(MAX_PAYLOAD);

    logic        started_reg,  started_next;
    logic        cvalid_reg,   cvalid_next;
    logic [7:0]  last_cnt_reg, last_cnt_next;
    logic [15:0] fill_reg,     fill_next;
    logic [15:0] space_reg,    space_next;

    always_comb begin
        logic [7:0]  dc;
        logic [15:0] size;
        logic [15:0] new_fill;
        logic        store;
        logic        idle;
        status_t     status;
        done_t       done;

        dc       = in_word.pkt_count - last_cnt_reg;
        size     = {5'd0, in_word.byte_len};
        new_fill = fill_reg + size;
        store    = 1'b0;
        idle     = 1'b0;
        status   = ST_OMIT;
        done     = DONE_CONTINUE;

        started_next  = started_reg;
        cvalid_next   = cvalid_reg;
        last_cnt_next = last_cnt_reg;
        fill_next     = fill_reg;
        space_next    = space_reg;

        result.ack_send      = 1'b0;
        result.ack_count     = 8'd0;
        result.write_enable  = 1'b0;
        result.write_offset  = 16'd0;
        result.total_bytes   = 16'd0;

        if (in_word.kind == KIND_TIMEOUT) begin
            status = ST_TIMEOUT;
            done   = DONE_ERROR;
            idle   = 1'b1;
        end else if (!cvalid_reg) begin
            if (in_word.first_flag) begin
                status = ST_FIRST;
                store  = 1'b1;
            end
        end else if (dc == 8'd0) begin
            status = ST_REPEAT;
            if (cfg.reliable_mode) begin
                result.ack_send  = 1'b1;
                result.ack_count = in_word.pkt_count;
            end
        end else if (dc != 8'd1) begin
            status = ST_MISSED;
            idle   = !cfg.reliable_mode;
        end else begin
            status = ST_ACCEPT;
            store  = 1'b1;
        end

        if (store) begin
            if (size > MaxPayload || size > space_reg) begin
                status = ST_SMALL;
                done   = DONE_ERROR;
                idle   = 1'b1;
            end else begin
                if (status == ST_FIRST) begin
                    started_next  = 1'b1;
                    cvalid_next   = 1'b1;
                    last_cnt_next = 8'd0;
                end else begin
                    last_cnt_next = last_cnt_reg + 8'd1;
                end
                if (cfg.reliable_mode) begin
                    result.ack_send  = 1'b1;
                    result.ack_count = in_word.pkt_count;
                end
                result.write_enable = 1'b1;
                result.write_offset = fill_reg;
                fill_next           = new_fill;
                space_next          = space_reg - size;
                if (in_word.last_flag) begin
                    done               = DONE_OK;
                    result.total_bytes = new_fill;
                    idle               = 1'b1;
                end
            end
        end

        if (idle) begin
            started_next  = 1'b0;
            cvalid_next   = 1'b0;
            last_cnt_next = 8'd0;
            fill_next     = 16'd0;
            space_next    = cfg.buffer_capacity;
        end

        result.status        = status;
        result.sequence_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            cvalid_reg   <= 1'b0;
            last_cnt_reg <= 8'd0;
            fill_reg     <= 16'd0;
            space_reg    <= CAPACITY_RESET;
        end else if (step) begin
            started_reg  <= started_next;
            cvalid_reg   <= cvalid_next;
            last_cnt_reg <= last_cnt_next;
            fill_reg     <= fill_next;
            space_reg    <= space_next;
        end else if (cfg.cap_load && !started_reg) begin
            space_reg    <= cfg.cap_value;
        end
    end

endmodule
`default_nettype wire

// File: design/packet_sequence_reassembler.sv
// Top level of the packet sequence reassembler.
// Usage:
//   s_ channel: one word per packet header (kind = data) or receive timeout
//   (kind = timeout). m_ channel: exactly one result word per input word, in
//   order: status, ack request, write offset, end-of-sequence code and total.
//   cfg channel: index 0 sets reliable mode, index 1 the buffer capacity;
//   other indexes are ignored. Write it only while no word is in flight.
//   A capacity write reaches the free-space count at once when no sequence
//   is open, otherwise at the next return to idle.
// Timing:
//   A word moves through an input register and a result register: the
//   result is valid once the word has passed both and holds until taken.
//   One word is taken per cycle while the result is not stalled; the
//   classification and offset add sit between the two registers, with the
//   sequence state updated at the same edge.
// Reset (aresetn low, synchronous): both registers empty, no sequence open,
//   reliable mode off, capacity 4096.
// Stall: while m_ready is low the result holds; the input register still
//   takes one word, then s_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module packet_sequence_reassembler
    import psr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  psr_in_t                     s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output psr_out_t                    m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    psr_cfg_t cfg;
    psr_out_t result;
    psr_in_t  in_data_reg;
    psr_out_t out_data_reg;
    logic     in_valid_reg;
    logic     out_valid_reg;
    logic     advance;
    logic     step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    psr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_word (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

endmodule
`default_nettype wire

// File: bench/packet_sequence_reassembler_tb.sv
// Self-checking testbench for the packet sequence reassembler: directed cases plus random traffic.
`timescale 1ns / 1ps
module packet_sequence_reassembler_tb;
    import psr_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    psr_in_t                s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    psr_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    packet_sequence_reassembler #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the reassembly state and registers
    logic        cfg_reliable;
    logic [15:0] cfg_capacity;
    logic        open_seq;
    logic        have_count;
    logic [7:0]  prev_count;
    logic [15:0] fill_pos;
    logic [15:0] room_left;

    psr_out_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int seq_completed = 0;
    int seq_errored = 0;
    int cfg_writes = 0;
    int unsigned cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void close_sequence();
        open_seq   = 1'b0;
        have_count = 1'b0;
        prev_count = 8'd0;
        fill_pos   = 16'd0;
        room_left  = cfg_capacity;
    endfunction

    function automatic psr_out_t predict_reassembly(psr_in_t w);
        psr_out_t   r;
        logic       store;
        logic [7:0] gap;
        r = '0;
        r.status = ST_OMIT;
        store = 1'b0;
        if (w.kind == KIND_TIMEOUT) begin
            r.status = ST_TIMEOUT;
            r.sequence_done = DONE_ERROR;
            close_sequence();
        end else if (!have_count) begin
            if (w.first_flag) begin
                r.status = ST_FIRST;
                store = 1'b1;
            end
        end else begin
            gap = w.pkt_count - prev_count;
            if (gap == 8'd0) begin
                r.status = ST_REPEAT;
                if (cfg_reliable) begin
                    r.ack_send = 1'b1;
                    r.ack_count = w.pkt_count;
                end
            end else if (gap > 8'd1) begin
                r.status = ST_MISSED;
                if (!cfg_reliable)
                    close_sequence();
            end else begin
                r.status = ST_ACCEPT;
                store = 1'b1;
            end
        end
        if (store) begin
            if ({5'd0, w.byte_len} > 16'(MAX_PAYLOAD) || {5'd0, w.byte_len} > room_left) begin
                r.status = ST_SMALL;
                r.sequence_done = DONE_ERROR;
                close_sequence();
            end else begin
                if (r.status == ST_FIRST) begin
                    open_seq   = 1'b1;
                    have_count = 1'b1;
                    prev_count = 8'd0;
                end else begin
                    prev_count = prev_count + 8'd1;
                end
                if (cfg_reliable) begin
                    r.ack_send = 1'b1;
                    r.ack_count = w.pkt_count;
                end
                r.write_enable = 1'b1;
                r.write_offset = fill_pos;
                fill_pos  = fill_pos + {5'd0, w.byte_len};
                room_left = room_left - {5'd0, w.byte_len};
                if (w.last_flag) begin
                    r.sequence_done = DONE_OK;
                    r.total_bytes = fill_pos;
                    close_sequence();
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        psr_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, m_data);
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                results_checked++;
                check_field("status", 32'(exp_r.status), 32'(m_data.status));
                check_field("ack_send", 32'(exp_r.ack_send), 32'(m_data.ack_send));
                check_field("ack_count", 32'(exp_r.ack_count), 32'(m_data.ack_count));
                check_field("write_enable", 32'(exp_r.write_enable),
                            32'(m_data.write_enable));
                check_field("write_offset", 32'(exp_r.write_offset),
                            32'(m_data.write_offset));
                check_field("sequence_done", 32'(exp_r.sequence_done),
                            32'(m_data.sequence_done));
                check_field("total_bytes", 32'(exp_r.total_bytes), 32'(m_data.total_bytes));
            end
        end
    end

    task automatic send_word(input kind_t kind, input logic [7:0] cnt, input logic first,
                             input logic last, input logic [10:0] size);
        psr_in_t  w;
        psr_out_t r;
        w = '{kind: kind, pkt_count: cnt, first_flag: first, last_flag: last,
              byte_len: size};
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        r = predict_reassembly(w);
        expected_results.push_back(r);
        words_sent++;
        if (r.sequence_done == DONE_OK)
            seq_completed++;
        else if (r.sequence_done == DONE_ERROR)
            seq_errored++;
    endtask

    // hold the sender until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (index == REG_RELIABLE_MODE) begin
            cfg_reliable = value[0];
        end else if (index == REG_BUFFER_CAPACITY) begin
            cfg_capacity = value;
            if (!open_seq)
                room_left = value;
        end
        @(posedge aclk);
    endtask

    function automatic logic [10:0] pick_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return 11'($urandom_range(0, 200));
        else if (sel < 85)
            return 11'($urandom_range(0, MAX_PAYLOAD));
        else if (sel < 90)
            return 11'(MAX_PAYLOAD);
        else if (sel < 95)
            return 11'($urandom_range(MAX_PAYLOAD + 1, 2047));
        else
            return 11'($urandom);
    endfunction

    task automatic send_random_sequence();
        int len;
        int roll;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if ($urandom_range(0, 7) == 0)
            send_word(KIND_DATA, 8'($urandom), 1'b0, 1'($urandom), pick_size());
        send_word(KIND_DATA, 8'($urandom), 1'b1, len == 1, pick_size());
        for (int i = 1; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                send_word(KIND_DATA, 8'(i - 1), $urandom_range(0, 9) == 0, 1'($urandom),
                          pick_size());
            else if (roll < 11)
                send_word(KIND_DATA, 8'(i + $urandom_range(2, 254)), 1'($urandom),
                          1'($urandom), pick_size());
            else if (roll < 13)
                send_word(KIND_TIMEOUT, 8'($urandom), 1'($urandom), 1'($urandom),
                          11'($urandom));
            send_word(KIND_DATA, 8'(i), $urandom_range(0, 9) == 0, i == len - 1, pick_size());
        end
    endtask

    task automatic test_unreliable_basics();
        send_word(KIND_DATA, 8'h37, 1'b0, 1'b1, 11'd5);
        send_word(KIND_TIMEOUT, 8'hFF, 1'b1, 1'b1, 11'h7FF);
        send_word(KIND_DATA, 8'hFF, 1'b1, 1'b0, 11'd0);
        send_word(KIND_DATA, 8'h01, 1'b0, 1'b0, 11'd1024);
        send_word(KIND_DATA, 8'h01, 1'b0, 1'b1, 11'd7);
        send_word(KIND_DATA, 8'h05, 1'b0, 1'b0, 11'd3);
        send_word(KIND_DATA, 8'h02, 1'b0, 1'b0, 11'd3);
        send_word(KIND_DATA, 8'h00, 1'b1, 1'b0, 11'd1025);
        send_word(KIND_DATA, 8'h80, 1'b1, 1'b1, 11'd2047);
        send_word(KIND_DATA, 8'h00, 1'b1, 1'b1, 11'd10);
    endtask

    task automatic test_reliable_acks();
        wait_drained();
        write_reg(REG_RELIABLE_MODE, 16'hFFFF);
        send_word(KIND_DATA, 8'h10, 1'b1, 1'b0, 11'd100);
        send_word(KIND_DATA, 8'h01, 1'b0, 1'b0, 11'd200);
        send_word(KIND_DATA, 8'h01, 1'b0, 1'b1, 11'd9);
        send_word(KIND_DATA, 8'h40, 1'b0, 1'b0, 11'd9);
        send_word(KIND_DATA, 8'h00, 1'b0, 1'b0, 11'd9);
        send_word(KIND_DATA, 8'h02, 1'b1, 1'b1, 11'd50);
        send_word(KIND_DATA, 8'h03, 1'b1, 1'b0, 11'd20);
        send_word(KIND_TIMEOUT, 8'h00, 1'b0, 1'b0, 11'd0);
    endtask

    task automatic test_capacity_limits();
        wait_drained();
        write_reg(REG_RELIABLE_MODE, 16'hFFFE);
        write_reg(REG_BUFFER_CAPACITY, 16'h0000);
        send_word(KIND_DATA, 8'h00, 1'b1, 1'b0, 11'd0);
        send_word(KIND_DATA, 8'h01, 1'b0, 1'b0, 11'd1);
        wait_drained();
        write_reg(REG_BUFFER_CAPACITY, 16'hFFFF);
        write_reg(8'hFF, 16'h0000);
        write_reg(8'h02, 16'h1234);
        send_word(KIND_DATA, 8'hAA, 1'b1, 1'b0, 11'd1024);
        send_word(KIND_DATA, 8'h01, 1'b0, 1'b0, 11'd1024);
        wait_drained();
        // capacity change while a sequence is open
        write_reg(REG_BUFFER_CAPACITY, 16'd10);
        send_word(KIND_DATA, 8'h02, 1'b0, 1'b1, 11'd1024);
        send_word(KIND_DATA, 8'h00, 1'b1, 1'b0, 11'd11);
        send_word(KIND_DATA, 8'h00, 1'b1, 1'b1, 11'd10);
    endtask

    task automatic test_count_wrap();
        wait_drained();
        write_reg(REG_RELIABLE_MODE, 16'h0001);
        write_reg(REG_BUFFER_CAPACITY, 16'hFFFF);
        send_word(KIND_DATA, 8'($urandom), 1'b1, 1'b0, 11'($urandom_range(0, 3)));
        for (int i = 1; i < 300; i++)
            send_word(KIND_DATA, 8'(i), 1'b0, i == 299, 11'($urandom_range(0, 3)));
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input logic reliable, input logic [15:0] cap,
                                       input int n_words);
        int start;
        wait_drained();
        write_reg(REG_RELIABLE_MODE, {15'($urandom), reliable});
        write_reg(REG_BUFFER_CAPACITY, cap);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start = words_sent;
        while (words_sent - start < n_words / 2)
            send_random_sequence();
        wait_drained();
        while (words_sent - start < n_words)
            send_random_sequence();
    endtask

    initial begin
        cfg_reliable = 1'b0;
        cfg_capacity = CAPACITY_RESET;
        close_sequence();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unreliable_basics();
        test_reliable_acks();
        test_capacity_limits();
        test_count_wrap();
        test_random_traffic(0, 0, 1'b0, CAPACITY_RESET, 280);
        test_random_traffic(63, 0, 1'b1, 16'hFFFF, 280);
        test_random_traffic(0, 63, 1'b0, 16'($urandom_range(300, 3000)), 280);
        test_random_traffic(20, 20, 1'b1, 16'($urandom), 280);

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Summary: %0d words sent, %0d results checked, %0d register writes",
                 words_sent, results_checked, cfg_writes);
        $display("Summary: %0d sequences completed, %0d ended with an error, %0d mismatches",
                 seq_completed, seq_errored, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
